>>> rtl/sparse_tube_pattern_sum_top_assert.svh
// Assertion macros for the sparse tube pattern sum block.
`ifndef SPARSE_TUBE_PATTERN_SUM_TOP_ASSERT_SVH
`define SPARSE_TUBE_PATTERN_SUM_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define STPS_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`define STPS_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
`else
`define STPS_ASSERT_NEXT(label, pre, post)
`define STPS_ASSERT_NOW(label, pre, post)
`endif
`endif

>>> rtl/stps_pkg.sv
// ----------------------------------------------------------------------------
// stps_pkg
// Types, constants and codes shared by the sparse tube pattern sum block.
// ----------------------------------------------------------------------------
package stps_pkg;

  localparam int MaxEntries = 256;
  localparam int IdWidth    = 16;
  localparam int ValueWidth = 16;
  localparam int AddrWidth  = $clog2(MaxEntries);
  localparam int CountWidth = $clog2(MaxEntries + 1);
  // The command queue depth is a power of two so that its pointers wrap freely.
  localparam int QueueDepth     = 2;
  localparam int QueuePtrWidth  = $clog2(QueueDepth);
  localparam int QueueFillWidth = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_PATTERN = 2'd2,
    OP_LOOKUP = 2'd3
  } op_t;

  typedef enum logic {
    REG_DEFAULT = 1'b0,
    REG_LIMIT   = 1'b1
  } reg_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [15:0]        element_id;
    logic signed [15:0] membership;
    logic               subtract;
    logic signed [31:0] base_sum;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               table_full;
    logic               insert_dropped;
  } out_item_t;

  // Classified command passed from the front part to the back part.
  typedef struct packed {
    op_t                   op;
    logic [IdWidth-1:0]    id;
    logic [ValueWidth-1:0] value;
    logic                  subtract;
    logic [31:0]           base_sum;
    logic                  last;
  } cmd_t;

endpackage

>>> rtl/stps_ram.sv
// ----------------------------------------------------------------------------
// stps_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stps_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/stps_front.sv
// ----------------------------------------------------------------------------
// stps_front
// Accepts input items, trims them into commands and queues them.
// ----------------------------------------------------------------------------
module stps_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  stps_pkg::in_item_t in_item,
  output logic               cmd_valid,
  input  logic               cmd_take,
  output stps_pkg::cmd_t     cmd
);

  localparam int PW = stps_pkg::QueuePtrWidth;
  localparam int FW = stps_pkg::QueueFillWidth;

  stps_pkg::cmd_t q [stps_pkg::QueueDepth];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [FW-1:0] fill;
  logic push;
  logic pop;
  stps_pkg::cmd_t incoming;

  assign in_stall  = (fill == FW'(stps_pkg::QueueDepth));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (fill != '0);
  assign pop       = cmd_valid && cmd_take;
  assign cmd       = q[rd_ptr];

  always_comb begin
    incoming.op       = stps_pkg::op_t'(in_item.operation);
    incoming.id       = in_item.element_id[stps_pkg::IdWidth-1:0];
    incoming.value    = in_item.membership[stps_pkg::ValueWidth-1:0];
    incoming.subtract = in_item.subtract;
    incoming.base_sum = in_item.base_sum;
    incoming.last     = in_item.last;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= incoming;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PW'(1);
      if (pop) rd_ptr <= rd_ptr + PW'(1);
      fill <= fill + FW'(push) - FW'(pop);
    end
  end

endmodule

>>> rtl/stps_back.sv
// ----------------------------------------------------------------------------
// stps_back
// Executes commands: table writes, linear search and the running sum.
// ----------------------------------------------------------------------------
module stps_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  output logic                       cmd_take,
  input  stps_pkg::cmd_t             cmd,
  input  logic [15:0]                default_membership,
  input  logic [8:0]                 size_limit,
  output logic                       out_valid,
  input  logic                       out_stall,
  output stps_pkg::out_item_t        out_item,
  output logic                       busy
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_READ   = 4'b0010,
    S_CHECK  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  localparam int AW = stps_pkg::AddrWidth;
  localparam int CW = stps_pkg::CountWidth;
  localparam int VW = stps_pkg::ValueWidth;

  state_t state;
  stps_pkg::cmd_t cur;
  logic [CW-1:0] entry_count;
  logic [CW-1:0] idx;
  logic [31:0] running_sum;
  logic run_active;
  logic [31:0] found;
  logic [stps_pkg::IdWidth-1:0] rd_id;
  logic [VW-1:0] rd_val;
  logic wr_en;
  logic [31:0] sum_next;
  logic [31:0] start_sum;
  logic [CW-1:0] count_next;
  logic [31:0] dflt;
  logic out_load;

  assign dflt = 32'(signed'(default_membership[VW-1:0]));

  assign wr_en = (state == S_IDLE) && cmd_valid && cmd.op == stps_pkg::OP_APPEND
                 && (entry_count != CW'(stps_pkg::MaxEntries));

  stps_ram #(.Width(stps_pkg::IdWidth), .Depth(stps_pkg::MaxEntries)) u_ids (
    .clk(clk), .wr_en(wr_en), .wr_addr(entry_count[AW-1:0]), .wr_data(cmd.id),
    .rd_addr(idx[AW-1:0]), .rd_data(rd_id)
  );

  stps_ram #(.Width(VW), .Depth(stps_pkg::MaxEntries)) u_vals (
    .clk(clk), .wr_en(wr_en), .wr_addr(entry_count[AW-1:0]), .wr_data(cmd.value),
    .rd_addr(idx[AW-1:0]), .rd_data(rd_val)
  );

  assign cmd_take = (state == S_IDLE) && cmd_valid
                    && !(out_valid && out_stall);
  assign busy = (state != S_IDLE) || out_valid;

  // A result is loaded by every append and by a finished lookup or last pattern id.
  assign out_load = (cmd_take && cmd.op == stps_pkg::OP_APPEND)
                    || (state == S_FINISH && !(out_valid && out_stall)
                        && (cur.op == stps_pkg::OP_LOOKUP || cur.last));

  assign start_sum = run_active ? running_sum : cur.base_sum;
  assign sum_next  = cur.subtract ? start_sum - found : start_sum + found;
  assign count_next = entry_count + CW'(1);

  always_ff @(posedge clk) begin
    if (cmd_take) cur <= cmd;
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      running_sum <= '0;
      run_active  <= 1'b0;
      out_valid   <= 1'b0;
      idx         <= '0;
      found       <= '0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd_take) begin
            idx <= '0;
            unique case (cmd.op)
              stps_pkg::OP_CLEAR: entry_count <= '0;
              stps_pkg::OP_APPEND: begin
                out_item.result_value <= '0;
                if (wr_en) begin
                  entry_count <= count_next;
                  out_item.table_full <= (count_next == CW'(size_limit));
                  out_item.insert_dropped <= 1'b0;
                end else begin
                  out_item.table_full <= (entry_count == CW'(size_limit));
                  out_item.insert_dropped <= 1'b1;
                end
              end
              default: begin
                found <= dflt;
                state <= S_READ;
              end
            endcase
          end
        end
        S_READ: begin
          // Address idx issued; data arrives next cycle.
          state <= (idx < entry_count) ? S_CHECK : S_FINISH;
        end
        S_CHECK: begin
          if (rd_id == cur.id) begin
            found <= 32'(signed'(rd_val));
            state <= S_FINISH;
          end else begin
            idx   <= idx + CW'(1);
            state <= S_READ;
          end
        end
        S_FINISH: begin
          if (!(out_valid && out_stall)) begin
            state <= S_IDLE;
            if (cur.op == stps_pkg::OP_LOOKUP) begin
              out_item.result_value   <= found;
              out_item.table_full     <= (entry_count == CW'(size_limit));
              out_item.insert_dropped <= 1'b0;
            end else begin
              running_sum <= sum_next;
              run_active  <= !cur.last;
              if (cur.last) begin
                out_item.result_value   <= sum_next;
                out_item.table_full     <= (entry_count == CW'(size_limit));
                out_item.insert_dropped <= 1'b0;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/sparse_tube_pattern_sum_top.sv
// ----------------------------------------------------------------------------
// sparse_tube_pattern_sum_top
// Sparse membership table with a default value, pattern sums and lookups.
// ----------------------------------------------------------------------------
// A user should know first that appends and clears take one cycle in the
// execution unit, while a pattern id or a lookup walks the stored entries
// one by one, because each probe is a read of the single-read-port entry
// memory followed by a compare: a search that misses all k stored entries
// costs 2*k + 3 cycles, and one that matches after j misses costs 2*j + 4.
// A two-entry queue between the front and the execution unit lets items be
// accepted while a search is running. A search also runs while a finished
// result waits, but no new command is taken and no further result is loaded
// until the waiting result leaves. Results leave in input order. The table
// is not cleared after reset; entries beyond the entry count are never read.
`include "sparse_tube_pattern_sum_top_assert.svh"

module sparse_tube_pattern_sum_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  stps_pkg::in_item_t    in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output stps_pkg::out_item_t   out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [15:0]           cfg_data
);

  logic           cmd_valid;
  logic           cmd_take;
  stps_pkg::cmd_t cmd;
  logic           busy;
  logic [15:0]    default_membership;
  logic [8:0]     size_limit;

  // Configuration is always accepted; it should be written only while no item
  // is in flight.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_membership <= '0;
      size_limit         <= 9'd256;
    end else if (cfg_valid && cfg_ready) begin
      unique case (stps_pkg::reg_t'(cfg_index))
        stps_pkg::REG_DEFAULT: default_membership <= cfg_data;
        stps_pkg::REG_LIMIT:   size_limit <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  stps_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_item(in_item), .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
  );

  stps_back u_back (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd),
    .default_membership(default_membership), .size_limit(size_limit),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .busy(busy)
  );

  // A stalled result stays presented.
  `STPS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item))
  // The execution unit never takes a command while a result is blocked.
  `STPS_ASSERT_NOW(a_no_take_blocked, out_valid && out_stall, !cmd_take)
  // A command is taken only when the unit is idle, apart from a result that is leaving.
  `STPS_ASSERT_NOW(a_take_when_idle, cmd_take, !busy || out_valid)

endmodule
